[hdl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked property that also holds while reset is asserted.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/scl2x_pkg.sv]
package scl2x_pkg;

    // Field widths fixed by the port list
    localparam int PIX_W    = 8;
    localparam int COL_W    = 9;
    localparam int ROW_W    = 12;
    localparam int SWIDTH_W = 10;
    localparam int CFG_W    = 12;

    localparam int DEF_MAX_WIDTH = 512;

    // Operation codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Configuration register indexes
    localparam logic CFG_SRC_WIDTH  = 1'b0;
    localparam logic CFG_SRC_HEIGHT = 1'b1;

    localparam logic [SWIDTH_W-1:0] RST_SRC_WIDTH  = SWIDTH_W'(256);
    localparam logic [ROW_W-1:0]    RST_SRC_HEIGHT = ROW_W'(224);

    typedef logic [PIX_W-1:0] t_pix;

    // Window stage: one emitting transaction waiting for line store data
    typedef struct packed {
        logic             first_col;   // column 0: P from the row-start register
        logic             last_col;    // right neighbour outside the image
        logic             has_above;
        logic             has_below;
        logic             centre_slot;
        t_pix             below;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             frame_last;
    } t_win;

    typedef struct packed {
        t_pix             top_left;
        t_pix             top_right;
        t_pix             bottom_left;
        t_pix             bottom_right;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             frame_last;
    } t_blk;

    typedef struct packed {
        t_pix tl;
        t_pix tr;
        t_pix bl;
        t_pix br;
    } t_quad;

    // Scale2x rule on neighbours above a, right b, left c, below d, centre p
    function automatic t_quad scale2x_rule(input t_pix a, input t_pix b, input t_pix c,
                                           input t_pix d, input t_pix p);
        t_quad q;
        q.tl = (c == a && c != d && a != b) ? a : p;
        q.tr = (a == b && a != c && b != d) ? b : p;
        q.bl = (d == c && d != b && c != a) ? c : p;
        q.br = (b == d && b != a && d != c) ? d : p;
        return q;
    endfunction

endpackage

[hdl/scale2x_pixel_doubler_core.sv]
`include "assert_macros.svh"

// Scale2x (EPX) doubler for 8-bit indexed pixels streamed in raster order. Every
// source pixel yields one 2x2 output block with its source column and row; the
// block of row r leaves when the pixel below it arrives, and after the last pixel
// of the frame one drain transaction per column flushes the bottom row, the final
// block carrying frame_last. One transaction is taken per clock unless o_stall is high;
// a block passes the window stage, then the output register. The line store is
// one memory of 2*MAX_WIDTH bytes with two registered read ports (centre row one
// column ahead, row above) and one write port, so one read-modify-write per
// clock sets the rate; it needs no clearing pass after reset. Row 0 pixels only
// fill the store, pixels sent while draining are dropped, drain steps outside a drain are
// ignored. Width and height must be written only while the block is idle (not enforced).
module scale2x_pixel_doubler_core #(
    parameter int MAX_WIDTH = scl2x_pkg::DEF_MAX_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [scl2x_pkg::CFG_W-1:0]   i_cfg_data,
    // source transactions
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_operation,
    input  logic [scl2x_pkg::PIX_W-1:0]   i_pixel,
    // result transactions
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [scl2x_pkg::PIX_W-1:0]   o_out_top_left,
    output logic [scl2x_pkg::PIX_W-1:0]   o_out_top_right,
    output logic [scl2x_pkg::PIX_W-1:0]   o_out_bottom_left,
    output logic [scl2x_pkg::PIX_W-1:0]   o_out_bottom_right,
    output logic [scl2x_pkg::COL_W-1:0]   o_source_col,
    output logic [scl2x_pkg::ROW_W-1:0]   o_source_row,
    output logic                          o_frame_last
);
    import scl2x_pkg::*;

    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int AW    = $clog2(2 * MAX_WIDTH);
    localparam int DEPTH = 2 * MAX_WIDTH;
    localparam int XW    = (CW + 1 > SWIDTH_W + 1) ? CW + 1 : SWIDTH_W + 1;

    // configuration registers
    logic [SWIDTH_W-1:0] r_src_width;
    logic [ROW_W-1:0]    r_src_height;

    // frame position
    logic [CW-1:0]    r_col,   n_col;
    logic [ROW_W-1:0] r_row,   n_row;
    logic             r_draining, n_draining;

    // row-start pixel of each line store slot
    t_pix r_row0 [2];

    // line store and its registered read data
    t_pix r_mem [DEPTH];
    t_pix r_rd_above;
    t_pix r_rd_next;

    // window stage
    logic r_win_v;
    t_win r_win;
    t_win n_win;
    t_pix r_prev_next;   // centre row, current column (read one step earlier)
    t_pix r_prev_centre; // centre row, previous column

    // two-entry output buffer
    logic r_out_v, r_skid_v;
    t_blk r_out, r_skid;

    logic              accept, is_pixel, is_drain, emit, mem_we, win_fire, out_pop;
    logic [XW-1:0]     w_eff, x_ext;
    logic [ROW_W-1:0]  h_eff;
    logic              col_end, row_end;
    logic              c_slot, a_slot;
    logic [CW-1:0]     col_next_rd;
    logic [AW-1:0]     addr_above, addr_next, addr_wr;
    t_pix              p, a, b, c, d;
    t_quad             quad;
    t_blk              blk;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= RST_SRC_WIDTH;
            r_src_height <= RST_SRC_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SRC_WIDTH:  r_src_width  <= i_cfg_data[SWIDTH_W-1:0];
                CFG_SRC_HEIGHT: r_src_height <= i_cfg_data[ROW_W-1:0];
                default:        r_src_width  <= r_src_width;
            endcase
        end
    end

    // effective frame size: zero acts as one, width clamped to the store
    always_comb begin
        if (r_src_width == '0)
            w_eff = XW'(1);
        else if (XW'(r_src_width) > XW'(MAX_WIDTH))
            w_eff = XW'(MAX_WIDTH);
        else
            w_eff = XW'(r_src_width);
        h_eff = (r_src_height == '0) ? ROW_W'(1) : r_src_height;
    end

    // handshake
    assign o_stall  = r_win_v && r_out_v && r_skid_v;
    assign accept   = i_valid && !o_stall;
    assign is_pixel = (i_operation == OP_PIXEL);
    assign is_drain = (i_operation == OP_DRAIN);
    assign emit     = accept && ((is_pixel && !r_draining && r_row != '0)
                                 || (is_drain && r_draining));
    assign mem_we   = accept && is_pixel && !r_draining;
    assign win_fire = r_win_v && !(r_out_v && r_skid_v);
    assign out_pop  = r_out_v && !i_stall;

    // position update
    assign x_ext   = XW'(r_col);
    assign col_end = (x_ext + XW'(1)) >= w_eff;
    assign row_end = ({1'b0, r_row} + (ROW_W+1)'(1)) >= {1'b0, h_eff};

    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_draining = r_draining;
        if (mem_we) begin
            if (col_end) begin
                n_col = '0;
                if (row_end) n_draining = 1'b1;
                else         n_row      = r_row + ROW_W'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end else if (accept && is_drain && r_draining) begin
            if (col_end) begin
                n_col      = '0;
                n_row      = '0;
                n_draining = 1'b0;
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_draining <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_draining <= n_draining;
        end
    end

    // line store addressing: a pixel centres on the row above it, a drain on its own row
    assign c_slot      = is_pixel ? ~r_row[0] : r_row[0];
    assign a_slot      = ~c_slot;
    assign col_next_rd = (r_col == CW'(MAX_WIDTH - 1)) ? r_col : r_col + CW'(1);
    assign addr_above  = (a_slot ? AW'(MAX_WIDTH) : AW'(0)) + AW'(r_col);
    assign addr_next   = (c_slot ? AW'(MAX_WIDTH) : AW'(0)) + AW'(col_next_rd);
    assign addr_wr     = (r_row[0] ? AW'(MAX_WIDTH) : AW'(0)) + AW'(r_col);

    // line store: reads return the contents from before this cycle's write
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_above <= r_mem[addr_above];
            r_rd_next  <= r_mem[addr_next];
        end
        if (mem_we) begin
            r_mem[addr_wr] <= i_pixel;
        end
        if (mem_we && r_col == '0) begin
            r_row0[r_row[0]] <= i_pixel;
        end
    end

    // window stage fields
    always_comb begin
        n_win.first_col   = (r_col == '0);
        n_win.last_col    = col_end;
        n_win.has_above   = is_pixel ? (r_row > ROW_W'(1)) : (r_row != '0);
        n_win.has_below   = is_pixel;
        n_win.centre_slot = c_slot;
        n_win.below       = i_pixel;
        n_win.col         = x_ext[COL_W-1:0];
        n_win.row         = is_pixel ? r_row - ROW_W'(1) : r_row;
        n_win.frame_last  = is_drain && col_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_v <= 1'b0;
        end else if (emit) begin
            r_win_v <= 1'b1;
        end else if (win_fire) begin
            r_win_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) r_win <= n_win;
        if (win_fire) begin
            r_prev_next   <= r_rd_next;
            r_prev_centre <= p;
        end
    end

    // neighbourhood and Scale2x rule
    always_comb begin
        p    = r_win.first_col ? r_row0[r_win.centre_slot] : r_prev_next;
        a    = r_win.has_above ? r_rd_above : p;
        b    = r_win.last_col  ? p : r_rd_next;
        c    = r_win.first_col ? p : r_prev_centre;
        d    = r_win.has_below ? r_win.below : p;
        quad = scale2x_rule(a, b, c, d, p);
        blk.top_left     = quad.tl;
        blk.top_right    = quad.tr;
        blk.bottom_left  = quad.bl;
        blk.bottom_right = quad.br;
        blk.col          = r_win.col;
        blk.row          = r_win.row;
        blk.frame_last   = r_win.frame_last;
    end

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (out_pop) begin
                if (r_skid_v) begin
                    r_out_v  <= 1'b1;
                    r_skid_v <= win_fire;
                end else begin
                    r_out_v  <= win_fire;
                end
            end else if (win_fire) begin
                if (r_out_v) r_skid_v <= 1'b1;
                else         r_out_v  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_pop) begin
            if (r_skid_v) begin
                r_out <= r_skid;
                if (win_fire) r_skid <= blk;
            end else if (win_fire) begin
                r_out <= blk;
            end
        end else if (win_fire) begin
            if (r_out_v) r_skid <= blk;
            else         r_out  <= blk;
        end
    end

    assign o_valid            = r_out_v;
    assign o_out_top_left     = r_out.top_left;
    assign o_out_top_right    = r_out.top_right;
    assign o_out_bottom_left  = r_out.bottom_left;
    assign o_out_bottom_right = r_out.bottom_right;
    assign o_source_col       = r_out.col;
    assign o_source_row       = r_out.row;
    assign o_frame_last       = r_out.frame_last;

    // checks
    `ASSERT_ALWAYS(a_skid_needs_out, i_clk, !(i_rst_n && r_skid_v) || r_out_v, "skid entry without output entry")
    `ASSERT_CLK(a_win_holds, i_clk, i_rst_n, (r_win_v && !win_fire) |=> (r_win_v && $stable(r_win)), "window stage lost a stalled block")
    `ASSERT_CLK(a_no_write_drain, i_clk, i_rst_n, mem_we |-> !r_draining, "line store written while draining")
    `ASSERT_CLK(a_drain_end, i_clk, i_rst_n, (accept && is_drain && r_draining && col_end) |=> (!r_draining && r_col == '0 && r_row == '0), "frame end did not return to start")

endmodule
